// ----- rtl/core/rafp_pkg.sv -----
// Shared types, constants and codes of the array frame parser.
`default_nettype none
package rafp_pkg;

	// Field widths and defaults
	localparam int COUNT_BITS_DEF  = 11;
	localparam int LENGTH_BITS_DEF = 25;
	localparam int FRAME_BITS      = 35;
	localparam int STATUS_BITS     = 3;
	localparam int CFG_INDEX_BITS  = 1;

	localparam longint ARRAY_COUNT_DEFAULT = 1024;
	localparam longint BULK_LENGTH_DEFAULT = 16 * 1024 * 1024;

	// Depth of the queue between classifier and parser (power of two)
	localparam int QUEUE_DEPTH = 2;

	// Register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_ARRAY_COUNT = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_BULK_LENGTH = 1'd1;

	// Result status codes
	localparam logic [STATUS_BITS-1:0] ST_COMPLETE    = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_EXP_ARRAY   = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_BAD_COUNT   = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_EXP_BULK    = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_BAD_LENGTH  = 3'd4;
	localparam logic [STATUS_BITS-1:0] ST_BAD_TERM    = 3'd5;

	// Characters of the protocol
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Classified byte handed from the front to the back
	typedef struct packed {
		logic       is_cr;
		logic       is_lf;
		logic       is_minus;
		logic       is_digit;
		logic       is_star;
		logic       is_dollar;
		logic [3:0] digit;
	} tok_t;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/rafp_front.sv -----
// Byte classifier and the short queue that feeds the parser.
`default_nettype none
module rafp_front
	import rafp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_ready,
	input  wire logic [7:0] byte_value,
	output logic            tok_valid,
	input  wire logic       tok_pop,
	output tok_t            tok
);

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	tok_t                tok_in;
	tok_t                mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                push;

	// Classify the incoming byte
	always_comb begin
		tok_in.is_cr     = (byte_value == CH_CR);
		tok_in.is_lf     = (byte_value == CH_LF);
		tok_in.is_minus  = (byte_value == CH_MINUS);
		tok_in.is_digit  = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
		tok_in.is_star   = (byte_value == CH_STAR);
		tok_in.is_dollar = (byte_value == CH_DOLLAR);
		tok_in.digit     = byte_value[3:0];
	end

	assign byte_ready = (count_q != CNT_BITS'(QUEUE_DEPTH));
	assign push       = byte_valid && byte_ready;
	assign tok_valid  = (count_q != '0);
	assign tok        = mem_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= tok_in;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (tok_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !tok_pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (!push && tok_pop) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/rafp_back.sv -----
// Frame parser state machine, limit registers and result register.
`default_nettype none
module rafp_back
	import rafp_pkg::*;
#(
	parameter int COUNT_BITS  = COUNT_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int CFG_BITS    = max_int(COUNT_BITS, LENGTH_BITS)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_write,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_BITS-1:0]       cfg_data,
	input  wire logic                      tok_valid,
	input  wire tok_t                      tok,
	output logic                           tok_pop,
	output logic                           result_valid,
	input  wire logic                      result_ready,
	output logic [STATUS_BITS-1:0]         status,
	output logic [FRAME_BITS-1:0]          frame_bytes,
	output logic [COUNT_BITS-1:0]          element_count
);

	localparam int ACC_BITS = max_int(COUNT_BITS, LENGTH_BITS) + 1;
	localparam int MUL_BITS = ACC_BITS + 4;
	localparam logic [ACC_BITS-1:0] ACC_CAP =
		ACC_BITS'((64'd1 << COUNT_BITS) + (64'd1 << LENGTH_BITS) - 64'd1);
	localparam logic [COUNT_BITS-1:0]  COUNT_RST  = COUNT_BITS'(ARRAY_COUNT_DEFAULT);
	localparam logic [LENGTH_BITS-1:0] LENGTH_RST = LENGTH_BITS'(BULK_LENGTH_DEFAULT);

	// Parser phases
	localparam logic [2:0] PH_ARRAY   = 3'd0;
	localparam logic [2:0] PH_BULK    = 3'd1;
	localparam logic [2:0] PH_PAYLOAD = 3'd2;
	localparam logic [2:0] PH_TERM1   = 3'd3;
	localparam logic [2:0] PH_TERM2   = 3'd4;

	// Limit registers
	logic [COUNT_BITS-1:0]  max_count_q;
	logic [LENGTH_BITS-1:0] max_length_q;

	// Parser state
	logic [2:0]             phase_q,   phase_d;
	logic [ACC_BITS-1:0]    acc_q,     acc_d;
	logic                   minus_q,   minus_d;
	logic                   digit_q,   digit_d;
	logic                   inv_q,     inv_d;
	logic [1:0]             lc_q,      lc_d;
	logic                   lead_q,    lead_d;
	logic                   pcr_q,     pcr_d;
	logic [COUNT_BITS-1:0]  left_q,    left_d;
	logic [COUNT_BITS-1:0]  decl_q,    decl_d;
	logic [LENGTH_BITS-1:0] pay_q,     pay_d;
	logic                   tbad_q,    tbad_d;
	logic [FRAME_BITS-1:0]  fc_q,      fc_d;

	// Result register
	logic                   res_valid_q;
	logic [STATUS_BITS-1:0] res_status_q;
	logic [FRAME_BITS-1:0]  res_bytes_q;
	logic [COUNT_BITS-1:0]  res_count_q;

	// Step signals
	logic                   take;
	logic                   emit;
	logic [STATUS_BITS-1:0] emit_status;
	logic [COUNT_BITS-1:0]  emit_count;
	logic [FRAME_BITS-1:0]  fc_inc;
	logic                   header;
	logic                   lead_match;
	logic [ACC_BITS-1:0]    limit;
	logic                   bad_lead;
	logic                   bad_num;
	logic [MUL_BITS-1:0]    mul;
	logic [1:0]             lc_a;
	logic                   lead_a;
	logic                   inv_a;
	logic [COUNT_BITS-1:0]  left_dec;

	assign take    = !res_valid_q || result_ready;
	assign tok_pop = tok_valid && take;

	assign fc_inc = (fc_q == '1) ? fc_q : fc_q + FRAME_BITS'(1);

	// Line judgment inputs
	assign header     = (phase_q != PH_BULK);
	assign lead_match = header ? tok.is_star : tok.is_dollar;
	assign limit      = header ? ACC_BITS'(max_count_q) : ACC_BITS'(max_length_q);
	assign bad_lead   = (lc_q != 2'd2) || !lead_q;
	assign bad_num    = inv_q || !digit_q || (minus_q && (acc_q != '0)) || (acc_q > limit);

	// Times ten plus digit
	assign mul = MUL_BITS'({acc_q, 3'b000}) + MUL_BITS'({acc_q, 1'b0}) + MUL_BITS'(tok.digit);

	assign left_dec = (left_q != '0) ? left_q - COUNT_BITS'(1) : left_q;

	// Next state for one classified byte
	always_comb begin
		phase_d     = phase_q;
		acc_d       = acc_q;
		minus_d     = minus_q;
		digit_d     = digit_q;
		inv_d       = inv_q;
		lc_d        = lc_q;
		lead_d      = lead_q;
		pcr_d       = pcr_q;
		left_d      = left_q;
		decl_d      = decl_q;
		pay_d       = pay_q;
		tbad_d      = tbad_q;
		fc_d        = fc_inc;
		emit        = 1'b0;
		emit_status = ST_COMPLETE;
		emit_count  = '0;
		lc_a        = lc_q;
		lead_a      = lead_q;
		inv_a       = inv_q;

		case (phase_q)
			PH_PAYLOAD: begin
				pay_d = pay_q - LENGTH_BITS'(1);
				if (pay_q == LENGTH_BITS'(1)) begin
					phase_d = PH_TERM1;
				end
			end
			PH_TERM1: begin
				tbad_d  = !tok.is_cr;
				phase_d = PH_TERM2;
			end
			PH_TERM2: begin
				if (tbad_q || !tok.is_lf) begin
					emit        = 1'b1;
					emit_status = ST_BAD_TERM;
				end else begin
					tbad_d = 1'b0;
					left_d = left_dec;
					if (left_dec == '0) begin
						emit        = 1'b1;
						emit_status = ST_COMPLETE;
						emit_count  = decl_q;
					end else begin
						phase_d = PH_BULK;
					end
				end
			end
			default: begin
				if (pcr_q && tok.is_lf) begin
					// End of header line: judge it and start the next line
					acc_d   = '0;
					minus_d = 1'b0;
					digit_d = 1'b0;
					inv_d   = 1'b0;
					lc_d    = 2'd0;
					lead_d  = 1'b0;
					pcr_d   = 1'b0;
					if (header) begin
						if (bad_lead) begin
							emit        = 1'b1;
							emit_status = ST_EXP_ARRAY;
						end else if (bad_num) begin
							emit        = 1'b1;
							emit_status = ST_BAD_COUNT;
						end else begin
							decl_d = acc_q[COUNT_BITS-1:0];
							left_d = acc_q[COUNT_BITS-1:0];
							if (acc_q[COUNT_BITS-1:0] == '0) begin
								emit        = 1'b1;
								emit_status = ST_COMPLETE;
							end else begin
								phase_d = PH_BULK;
							end
						end
					end else begin
						if (bad_lead) begin
							emit        = 1'b1;
							emit_status = ST_EXP_BULK;
						end else if (bad_num) begin
							emit        = 1'b1;
							emit_status = ST_BAD_LENGTH;
						end else begin
							pay_d   = acc_q[LENGTH_BITS-1:0];
							phase_d = (acc_q[LENGTH_BITS-1:0] == '0) ? PH_TERM1 : PH_PAYLOAD;
						end
					end
				end else begin
					// A held CR not followed by LF counts as a line character
					if (pcr_q) begin
						lc_a   = (lc_q == 2'd2) ? 2'd2 : lc_q + 2'd1;
						lead_a = (lc_q == 2'd0) ? 1'b0 : lead_q;
						inv_a  = inv_q | (lc_q != 2'd0);
					end
					lc_d   = lc_a;
					lead_d = lead_a;
					inv_d  = inv_a;
					pcr_d  = tok.is_cr;
					if (!tok.is_cr) begin
						if (lc_a == 2'd0) begin
							lead_d = lead_match;
						end else if (tok.is_minus && (lc_a == 2'd1)) begin
							minus_d = 1'b1;
						end else if (tok.is_digit) begin
							acc_d   = (mul > MUL_BITS'(ACC_CAP)) ? ACC_CAP : mul[ACC_BITS-1:0];
							digit_d = 1'b1;
						end else begin
							inv_d = 1'b1;
						end
						lc_d = (lc_a == 2'd2) ? 2'd2 : lc_a + 2'd1;
					end
					phase_d = header ? PH_ARRAY : PH_BULK;
				end
			end
		endcase

		// A result ends the frame
		if (emit) begin
			phase_d = PH_ARRAY;
			acc_d   = '0;
			minus_d = 1'b0;
			digit_d = 1'b0;
			inv_d   = 1'b0;
			lc_d    = 2'd0;
			lead_d  = 1'b0;
			pcr_d   = 1'b0;
			left_d  = '0;
			decl_d  = '0;
			pay_d   = '0;
			tbad_d  = 1'b0;
			fc_d    = '0;
		end
	end

	// Limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q  <= COUNT_RST;
			max_length_q <= LENGTH_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MAX_ARRAY_COUNT: max_count_q  <= cfg_data[COUNT_BITS-1:0];
				REG_MAX_BULK_LENGTH: max_length_q <= cfg_data[LENGTH_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ARRAY;
			acc_q   <= '0;
			minus_q <= 1'b0;
			digit_q <= 1'b0;
			inv_q   <= 1'b0;
			lc_q    <= 2'd0;
			lead_q  <= 1'b0;
			pcr_q   <= 1'b0;
			left_q  <= '0;
			decl_q  <= '0;
			pay_q   <= '0;
			tbad_q  <= 1'b0;
			fc_q    <= '0;
		end else if (tok_pop) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			minus_q <= minus_d;
			digit_q <= digit_d;
			inv_q   <= inv_d;
			lc_q    <= lc_d;
			lead_q  <= lead_d;
			pcr_q   <= pcr_d;
			left_q  <= left_d;
			decl_q  <= decl_d;
			pay_q   <= pay_d;
			tbad_q  <= tbad_d;
			fc_q    <= fc_d;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tok_pop && emit) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (tok_pop && emit) begin
			res_status_q <= emit_status;
			res_bytes_q  <= fc_inc;
			res_count_q  <= emit_count;
		end
	end

	assign result_valid  = res_valid_q;
	assign status        = res_status_q;
	assign frame_bytes   = res_bytes_q;
	assign element_count = res_count_q;

	// Checks
	a_count_only_complete: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_status_q != ST_COMPLETE) |-> res_count_q == '0)
		else $error("element count on an error result");

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> pay_q != '0)
		else $error("payload phase with nothing left");

	a_elements_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BULK) || (phase_q == PH_PAYLOAD) || (phase_q == PH_TERM1) ||
		(phase_q == PH_TERM2) |-> left_q != '0)
		else $error("inside a frame with no elements left");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		tok_pop && emit |=> (fc_q == '0) && (phase_q == PH_ARRAY) && res_valid_q)
		else $error("frame not restarted after a result");

endmodule
`default_nettype wire

// ----- rtl/core/resp_array_frame_parser.sv -----
// Top level of the array frame parser: classifier, queue and parser.
//
// Takes one request byte per transaction and frames messages of the form
// '*' count CR LF followed by count bulk strings ('$' length CR LF payload
// CR LF). A result transaction is given when a frame completes or a protocol
// error is found; it carries the status, the saturating byte count of the
// frame up to that byte, and the declared element count on completion. After
// any result the next byte starts a new frame. Sustained rate is one byte per
// clock cycle unless result_ready stalls: each byte makes one pass through the
// parser state machine and its times-ten accumulator. A byte is classified
// into a two-entry queue; its result, if any, is registered at the output when
// popped; the queue and the output register let either side stall on its own.
// The user writes the limit registers through cfg_write while no frame is in
// flight; the block does not check it. There is no clearing pass after reset.
`default_nettype none
module resp_array_frame_parser
	import rafp_pkg::*;
#(
	parameter int COUNT_BITS  = COUNT_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       cfg_write,
	input  wire logic [CFG_INDEX_BITS-1:0]                  cfg_index,
	input  wire logic [max_int(COUNT_BITS, LENGTH_BITS)-1:0] cfg_data,
	input  wire logic                                       byte_valid,
	output logic                                            byte_ready,
	input  wire logic [7:0]                                 byte_value,
	output logic                                            result_valid,
	input  wire logic                                       result_ready,
	output logic [STATUS_BITS-1:0]                          status,
	output logic [FRAME_BITS-1:0]                           frame_bytes,
	output logic [COUNT_BITS-1:0]                           element_count
);

	localparam int CFG_BITS = max_int(COUNT_BITS, LENGTH_BITS);

	tok_t tok;
	logic tok_valid;
	logic tok_pop;

	// Front: classify and queue
	rafp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_value (byte_value),
		.tok_valid  (tok_valid),
		.tok_pop    (tok_pop),
		.tok        (tok)
	);

	// Back: parse and report
	rafp_back #(
		.COUNT_BITS  (COUNT_BITS),
		.LENGTH_BITS (LENGTH_BITS),
		.CFG_BITS    (CFG_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.tok_valid     (tok_valid),
		.tok           (tok),
		.tok_pop       (tok_pop),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.status        (status),
		.frame_bytes   (frame_bytes),
		.element_count (element_count)
	);

endmodule
`default_nettype wire

// ----- dv/resp_array_frame_parser_tb.sv -----
// Self-checking testbench for the array frame parser: random request streams against a predictor.
module resp_array_frame_parser_tb
	import rafp_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// Accumulator saturation point, above both register maxima
	localparam longint ACC_CAP = (longint'(1) << COUNT_BITS_DEF) - 1 +
		(longint'(1) << LENGTH_BITS_DEF) - 1 + 1;
	localparam logic [FRAME_BITS-1:0] FRAME_MAX = {FRAME_BITS{1'b1}};
	localparam int MAX_REPORTS = 50;

	typedef enum logic [2:0] {
		AWAIT_ARRAY,
		AWAIT_BULK,
		IN_PAYLOAD,
		TERM_CR,
		TERM_LF
	} parse_phase_e;

	typedef enum int {
		LINE_OK,
		LINE_BAD_LEAD,
		LINE_BAD_NUMBER
	} line_verdict_e;

	typedef struct packed {
		logic [STATUS_BITS-1:0]    status;
		logic [FRAME_BITS-1:0]     frame_bytes;
		logic [COUNT_BITS_DEF-1:0] element_count;
	} frame_result_t;

	// Tracks the parser state per accepted byte and holds the frame results it owes
	class frame_tracker;
		logic [COUNT_BITS_DEF-1:0]  lim_count;
		logic [LENGTH_BITS_DEF-1:0] lim_length;

		parse_phase_e               ph;
		logic [25:0]                acc;
		bit                         minus_seen;
		bit                         digit_seen;
		bit                         line_bad;
		logic [1:0]                 nchars;
		bit                         lead_ok;
		bit                         prev_cr;
		logic [COUNT_BITS_DEF-1:0]  elems_left;
		logic [COUNT_BITS_DEF-1:0]  elems_decl;
		logic [LENGTH_BITS_DEF-1:0] pay_left;
		bit                         term_bad;
		logic [FRAME_BITS-1:0]      fcount;

		frame_result_t              owed_frames[$];
		int                         errors;
		int                         completed;
		int                         failed;

		function new();
			lim_count  = COUNT_BITS_DEF'(ARRAY_COUNT_DEFAULT);
			lim_length = LENGTH_BITS_DEF'(BULK_LENGTH_DEFAULT);
			errors     = 0;
			completed  = 0;
			failed     = 0;
			clear_frame();
		endfunction

		function void report(string msg);
			if (errors < MAX_REPORTS)
				$display("mismatch: %s", msg);
			errors++;
		endfunction

		function void set_limit(logic [CFG_INDEX_BITS-1:0] idx, longint val);
			if (idx == REG_MAX_ARRAY_COUNT)
				lim_count = COUNT_BITS_DEF'(val);
			else if (idx == REG_MAX_BULK_LENGTH)
				lim_length = LENGTH_BITS_DEF'(val);
		endfunction

		function int pending();
			return owed_frames.size();
		endfunction

		function bit at_frame_start();
			return fcount == '0;
		endfunction

		// A byte that drives the current frame toward its end
		function logic [7:0] closing_byte();
			case (ph)
				AWAIT_ARRAY, AWAIT_BULK: return prev_cr ? CH_LF : CH_CR;
				IN_PAYLOAD: return 8'h78;
				default: return 8'h5A;
			endcase
		endfunction

		function void clear_line();
			acc        = '0;
			minus_seen = 1'b0;
			digit_seen = 1'b0;
			line_bad   = 1'b0;
			nchars     = '0;
			lead_ok    = 1'b0;
			prev_cr    = 1'b0;
		endfunction

		function void clear_frame();
			clear_line();
			ph         = AWAIT_ARRAY;
			elems_left = '0;
			elems_decl = '0;
			pay_left   = '0;
			term_bad   = 1'b0;
			fcount     = '0;
		endfunction

		function void owe(logic [STATUS_BITS-1:0] st, logic [COUNT_BITS_DEF-1:0] cnt);
			frame_result_t r;
			r.status        = st;
			r.frame_bytes   = fcount;
			r.element_count = cnt;
			owed_frames.push_back(r);
			clear_frame();
		endfunction

		// One character of a header line, the lead included
		function void line_char(logic [7:0] c, logic [7:0] lead);
			longint v;
			if (nchars == 0) begin
				lead_ok = (c == lead);
			end else if (c == CH_MINUS && nchars == 1) begin
				minus_seen = 1'b1;
			end else if (c >= CH_ZERO && c <= CH_NINE) begin
				v = longint'(acc) * 10 + longint'(c - CH_ZERO);
				acc = (v > ACC_CAP) ? 26'(ACC_CAP) : 26'(v);
				digit_seen = 1'b1;
			end else begin
				line_bad = 1'b1;
			end
			if (nchars < 2)
				nchars++;
		endfunction

		// Advance the predicted parser by one accepted byte
		function void note_byte(logic [7:0] c);
			bit            hdr;
			logic [7:0]    lead;
			longint        limit;
			longint        v;
			line_verdict_e verdict;
			if (fcount != FRAME_MAX)
				fcount++;
			case (ph)
				IN_PAYLOAD: begin
					pay_left = pay_left - 1'b1;
					if (pay_left == '0)
						ph = TERM_CR;
					return;
				end
				TERM_CR: begin
					term_bad = (c != CH_CR);
					ph = TERM_LF;
					return;
				end
				TERM_LF: begin
					if (term_bad || c != CH_LF) begin
						owe(ST_BAD_TERM, '0);
						return;
					end
					term_bad = 1'b0;
					if (elems_left != '0)
						elems_left = elems_left - 1'b1;
					if (elems_left == '0) begin
						owe(ST_COMPLETE, elems_decl);
						return;
					end
					ph = AWAIT_BULK;
					return;
				end
				default: ;
			endcase

			hdr  = (ph != AWAIT_BULK);
			lead = hdr ? CH_STAR : CH_DOLLAR;
			if (prev_cr) begin
				// CR LF closes the line; judge lead, then the number
				if (c == CH_LF) begin
					limit = hdr ? longint'(lim_count) : longint'(lim_length);
					if (nchars < 2 || !lead_ok)
						verdict = LINE_BAD_LEAD;
					else if (line_bad || !digit_seen || (minus_seen && acc != '0) ||
							longint'(acc) > limit)
						verdict = LINE_BAD_NUMBER;
					else
						verdict = LINE_OK;
					v = longint'(acc);
					clear_line();
					if (hdr) begin
						if (verdict == LINE_BAD_LEAD) begin
							owe(ST_EXP_ARRAY, '0);
						end else if (verdict == LINE_BAD_NUMBER) begin
							owe(ST_BAD_COUNT, '0);
						end else begin
							elems_decl = COUNT_BITS_DEF'(v);
							elems_left = elems_decl;
							if (elems_left == '0)
								owe(ST_COMPLETE, '0);
							else
								ph = AWAIT_BULK;
						end
					end else begin
						if (verdict == LINE_BAD_LEAD) begin
							owe(ST_EXP_BULK, '0);
						end else if (verdict == LINE_BAD_NUMBER) begin
							owe(ST_BAD_LENGTH, '0);
						end else begin
							pay_left = LENGTH_BITS_DEF'(v);
							ph = (pay_left == '0) ? TERM_CR : IN_PAYLOAD;
						end
					end
					return;
				end
				// lone CR counts as line content
				line_char(CH_CR, lead);
				prev_cr = 1'b0;
			end
			if (c == CH_CR)
				prev_cr = 1'b1;
			else
				line_char(c, lead);
		endfunction

		// Compare one result transaction with the oldest owed frame
		function void check_result(logic [STATUS_BITS-1:0] st, logic [FRAME_BITS-1:0] fb,
				logic [COUNT_BITS_DEF-1:0] ec);
			frame_result_t e;
			if (owed_frames.size() == 0) begin
				report($sformatf("unexpected result status %0d frame_bytes %0d count %0d",
					st, fb, ec));
				return;
			end
			e = owed_frames.pop_front();
			if (st !== e.status)
				report($sformatf("status %0d, want %0d", st, e.status));
			if (fb !== e.frame_bytes)
				report($sformatf("frame_bytes %0d, want %0d", fb, e.frame_bytes));
			if (ec !== e.element_count)
				report($sformatf("element_count %0d, want %0d", ec, e.element_count));
			if (e.status == ST_COMPLETE)
				completed++;
			else
				failed++;
		endfunction
	endclass

	localparam int CFG_W = (COUNT_BITS_DEF > LENGTH_BITS_DEF) ? COUNT_BITS_DEF : LENGTH_BITS_DEF;
	localparam int NUM_PHASES  = 8;
	localparam int PHASE_BYTES = 260;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam longint CYCLE_LIMIT = 400000;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_write;
	logic [CFG_INDEX_BITS-1:0]   cfg_index;
	logic [CFG_W-1:0]            cfg_data;
	logic                        byte_valid;
	logic                        byte_ready;
	logic [7:0]                  byte_value;
	logic                        result_valid;
	logic                        result_ready;
	logic [STATUS_BITS-1:0]      status;
	logic [FRAME_BITS-1:0]       frame_bytes;
	logic [COUNT_BITS_DEF-1:0]   element_count;

	frame_tracker tracker;
	logic [7:0]   fq[$];
	int           idle_pct;
	int           stall_pct;
	int           hold_requests;
	longint       bytes_sent;
	int           settings_used;
	longint       cycles;

	resp_array_frame_parser u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.byte_valid    (byte_valid),
		.byte_ready    (byte_ready),
		.byte_value    (byte_value),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.status        (status),
		.frame_bytes   (frame_bytes),
		.element_count (element_count)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles, tracker.pending());
		$display("resp_array_frame_parser_tb: done, errors");
		$finish;
	end

	// Result side: check accepted results, stall at random, long hold on request
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready)
				tracker.check_result(status, frame_bytes, element_count);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offer one byte; returns at the edge where the transaction is taken
	task automatic send_byte(input logic [7:0] b);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			byte_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		byte_valid <= 1'b1;
		byte_value <= b;
		do @(posedge clk); while (!byte_ready);
		tracker.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_queue();
		foreach (fq[i])
			send_byte(fq[i]);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input longint val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
		@(posedge clk);
		cfg_write <= 1'b0;
		tracker.set_limit(idx, val);
	endtask

	task automatic set_limits(input longint count, input longint len);
		write_reg(REG_MAX_ARRAY_COUNT, count);
		write_reg(REG_MAX_BULK_LENGTH, len);
		settings_used++;
	endtask

	// Stop offering, then wait for all owed results and let the pipe settle
	task automatic wait_for_results();
		byte_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(9))
			0: return CH_CR;
			1: return CH_LF;
			2: return CH_STAR;
			3: return CH_DOLLAR;
			4: return CH_MINUS;
			5: return CH_ZERO + 8'($urandom_range(9));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic put_digits(input longint v, input int zeros);
		string s;
		repeat (zeros) fq.push_back(CH_ZERO);
		s = $sformatf("%0d", v);
		foreach (s[i])
			fq.push_back(s[i]);
	endtask

	// Header line that the parser accepts, in varied spellings
	task automatic valid_line(input logic [7:0] lead, input longint v);
		fq.push_back(lead);
		if (v == 0 && $urandom_range(3) == 0)
			fq.push_back(CH_MINUS);
		put_digits(v, ($urandom_range(4) == 0) ? $urandom_range(3, 1) : 0);
		fq.push_back(CH_CR);
		fq.push_back(CH_LF);
	endtask

	// Header line with one kind of defect
	task automatic bad_line(input logic [7:0] lead, input longint limit);
		logic [7:0] b;
		case ($urandom_range(7))
			0: begin
				b = 8'($urandom_range(255));
				if (b == lead)
					b ^= 8'h01;
				fq.push_back(b);
				put_digits(1, 0);
			end
			1: begin
				// short or empty line
				if ($urandom_range(1))
					fq.push_back(lead);
			end
			2: begin
				fq.push_back(lead);
				put_digits(limit + 1, 0);
			end
			3: begin
				// negative, or minus without digits
				fq.push_back(lead);
				fq.push_back(CH_MINUS);
				if ($urandom_range(3) != 0)
					put_digits($urandom_range(99, 1), 0);
			end
			4: begin
				// overlong number, saturates the accumulator
				fq.push_back(lead);
				repeat ($urandom_range(20, 9)) fq.push_back(CH_NINE);
			end
			5: begin
				// lone CR inside the number
				fq.push_back(lead);
				fq.push_back(CH_ZERO + 8'd1);
				fq.push_back(CH_CR);
				fq.push_back(CH_ZERO + 8'd2);
			end
			6: begin
				// bare LF inside the number
				fq.push_back(lead);
				fq.push_back(CH_ZERO + 8'd1);
				fq.push_back(CH_LF);
				fq.push_back(CH_ZERO + 8'd2);
			end
			default: begin
				fq.push_back(lead);
				fq.push_back(CH_MINUS);
				fq.push_back(CH_MINUS);
				fq.push_back(CH_ZERO + 8'd1);
			end
		endcase
		fq.push_back(CH_CR);
		fq.push_back(CH_LF);
	endtask

	// One random unit of stimulus: mostly well-formed frames, some broken, some noise
	task automatic build_frame();
		int kind;
		int n;
		int len;
		int hi;
		int i;
		int t;
		kind = $urandom_range(99);
		fq.delete();
		if (kind < 6) begin
			repeat ($urandom_range(8, 1)) fq.push_back(noise_byte());
			return;
		end
		if (kind < 14) begin
			bad_line(CH_STAR, tracker.lim_count);
			return;
		end
		hi = (tracker.lim_count < 4) ? int'(tracker.lim_count) : 4;
		n = $urandom_range(hi, 0);
		if ($urandom_range(9) == 0 && tracker.lim_count <= 8)
			n = tracker.lim_count;
		valid_line(CH_STAR, n);
		for (i = 0; i < n; i++) begin
			if (kind < 20 && i == n - 1) begin
				bad_line(CH_DOLLAR, tracker.lim_length);
				return;
			end
			hi = (tracker.lim_length < 12) ? int'(tracker.lim_length) : 12;
			if ($urandom_range(19) == 0)
				hi = (tracker.lim_length < 300) ? int'(tracker.lim_length) : 300;
			len = $urandom_range(hi, 0);
			if ($urandom_range(9) == 0 && tracker.lim_length <= 300)
				len = tracker.lim_length;
			valid_line(CH_DOLLAR, len);
			repeat (len) fq.push_back(8'($urandom_range(255)));
			fq.push_back(CH_CR);
			fq.push_back(CH_LF);
		end
		if (kind < 28 && n > 0) begin
			// spoil one or both terminator bytes of the last element
			t = $urandom_range(2);
			if (t != 1)
				fq[fq.size() - 2] = noise_byte();
			if (t != 0)
				fq[fq.size() - 1] = noise_byte();
		end else if (kind < 40) begin
			fq[$urandom_range(fq.size() - 1)] = noise_byte();
		end
	endtask

	// Main sequence
	initial begin
		int     p;
		longint phase_start;
		tracker = new();
		idle_pct      = 0;
		stall_pct     = 0;
		hold_requests = 0;
		bytes_sent    = 0;
		settings_used = 1;
		arst_n     <= 1'b0;
		cfg_write  <= 1'b0;
		cfg_index  <= '0;
		cfg_data   <= '0;
		byte_valid <= 1'b0;
		byte_value <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: minus zero with zero count, zero length with a bad terminator,
		// bare LF with extreme byte values, lone CR before the line end
		fq = '{CH_STAR, CH_MINUS, CH_ZERO, CH_CR, CH_LF,
			CH_STAR, CH_ZERO + 8'd1, CH_CR, CH_LF, CH_DOLLAR, CH_ZERO, CH_CR, CH_LF,
			8'h78, CH_LF,
			8'hFF, 8'h00, CH_LF, CH_CR, CH_LF,
			CH_STAR, CH_CR, CH_CR, CH_LF};
		send_queue();
		wait_for_results();

		// Random phases, each with its own limits and idling pattern
		for (p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: ;
				1: set_limits(4, 8);
				2: set_limits(0, 0);
				3: set_limits(ARRAY_COUNT_DEFAULT, BULK_LENGTH_DEFAULT);
				4: set_limits(1, 1);
				5: set_limits($urandom_range(6), $urandom_range(40));
				6: set_limits(ARRAY_COUNT_DEFAULT, 3);
				default: set_limits(2, BULK_LENGTH_DEFAULT);
			endcase
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 66; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 66; end
				default: begin idle_pct = 17; stall_pct = 17; end
			endcase
			// back-pressure: result side holds off while bytes keep coming
			if (p == 0)
				hold_requests++;
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				build_frame();
				send_queue();
			end
			// finish any frame left open so limits change only at a frame boundary
			while (!tracker.at_frame_start())
				send_byte(tracker.closing_byte());
			wait_for_results();
		end

		$display("summary: %0d bytes under %0d limit settings, %0d idling patterns",
			bytes_sent, settings_used, 4);
		$display("summary: %0d frames complete, %0d protocol error results, %0d mismatches",
			tracker.completed, tracker.failed, tracker.errors);
		if (tracker.errors == 0)
			$display("resp_array_frame_parser_tb: done, clean");
		else
			$display("resp_array_frame_parser_tb: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/rafp_pkg.sv
rtl/core/rafp_front.sv
rtl/core/rafp_back.sv
rtl/core/resp_array_frame_parser.sv
dv/resp_array_frame_parser_tb.sv
